/* rtl/core/chms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chms_pkg: shared types and constants
// Sizes, field widths and the controller/datapath command and status structs.
// ---------------------------------------------------------------------------
package chms_pkg;
  localparam int BUCKETS     = 64;
  localparam int ENTRIES     = 256;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int BKT_W       = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W       = $clog2(ENTRIES + 1);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_SET = 1'b1;

  typedef struct packed {
    logic capture;   // latch the request, read the bucket head
    logic load_head; // head read data becomes the walk pointer
    logic rd_node;   // read the node at the walk pointer
    logic advance;   // follow the node's next link
    logic do_write;  // commit the set
    logic set_res;   // build the result
  } chms_cmd_t;

  typedef struct packed {
    logic ptr_ok;    // pointer is live and step budget not used up
    logic key_eq;    // node key matches
    logic is_set;
  } chms_sts_t;
endpackage
`default_nettype wire

/* rtl/core/chms_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chms_req_if / chms_rsp_if: valid/ready channels
// Request and response channels of the store.
// ---------------------------------------------------------------------------
interface chms_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] key;
  logic [31:0] value;
  modport source (output valid, operation, key, value, input ready);
  modport sink   (input valid, operation, key, value, output ready);
endinterface

interface chms_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] value_out;
  logic        inserted;
  logic        full_res;
  modport source (output valid, found, value_out, inserted, full_res, input ready);
  modport sink   (input valid, found, value_out, inserted, full_res, output ready);
endinterface
`default_nettype wire

/* rtl/core/chms_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chms_ctrl: request sequencer
// Steps each request through head read, chain walk and commit.
// ---------------------------------------------------------------------------
module chms_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  input  wire chms_pkg::chms_sts_t sts,
  output chms_pkg::chms_cmd_t     cmd
);
  import chms_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       rsp_valid_r, rsp_valid_nxt;

  // A new request waits while a request is in progress or a result is still held.
  assign req_ready = (state_r == S_IDLE) && !(rsp_valid_r && !rsp_ready);
  assign rsp_valid = rsp_valid_r;

  always_comb begin
    state_nxt     = state_r;
    rsp_valid_nxt = rsp_valid_r && !rsp_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (req_valid && req_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_HEAD;
        end
      end
      S_HEAD: state_nxt = S_LOAD;
      S_LOAD: begin
        cmd.load_head = 1'b1;
        state_nxt     = S_READ;
      end
      S_READ: begin
        if (sts.ptr_ok) begin
          cmd.rd_node = 1'b1;
          state_nxt   = S_CMP;
        end else begin
          cmd.do_write = sts.is_set;
          cmd.set_res  = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_CMP: begin
        if (sts.key_eq) begin
          cmd.do_write = sts.is_set;
          cmd.set_res  = 1'b1;
          state_nxt    = S_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_DONE: begin
        rsp_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rsp_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rsp_valid_r <= rsp_valid_nxt;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/chms_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chms_dp: store datapath
// Bucket heads, node pool memories, walk pointer and result register.
// ---------------------------------------------------------------------------
module chms_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire chms_pkg::chms_cmd_t cmd,
  output chms_pkg::chms_sts_t      sts,
  input  wire logic                in_op,
  input  wire logic [31:0]         in_key,
  input  wire logic [31:0]         in_val,
  output logic                     res_found,
  output logic [31:0]              res_value,
  output logic                     res_inserted,
  output logic                     res_full
);
  import chms_pkg::*;

  logic [PTR_W-1:0] head_mem [BUCKETS];
  logic [BUCKETS-1:0] head_vld_r;
  logic [KEY_WIDTH-1:0]   key_mem [ENTRIES];
  logic [VALUE_WIDTH-1:0] val_mem [ENTRIES];
  logic [PTR_W-1:0]       nxt_mem [ENTRIES];

  logic                   op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [BKT_W-1:0]       bkt_r;
  logic [PTR_W-1:0]       head_rd_r, ptr_r, hit_r, steps_r, count_r;
  logic [KEY_WIDTH-1:0]   nkey_r;
  logic [PTR_W-1:0]       nnxt_r;
  logic                   hvld_r;
  logic [PTR_W-1:0]       head_eff;
  logic                   hit_sel;
  logic [IDX_W-1:0]       wr_idx;

  assign head_eff   = hvld_r ? head_rd_r : PTR_W'(ENTRIES);
  assign sts.ptr_ok = (ptr_r < count_r) && (steps_r < count_r);
  assign sts.key_eq = (nkey_r == key_r);
  assign sts.is_set = op_r;
  assign hit_sel    = cmd.set_res && !sts.ptr_ok ? 1'b0 : 1'b1;
  assign wr_idx     = hit_sel ? ptr_r[IDX_W-1:0] : count_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      key_r <= KEY_WIDTH'(in_key);
      val_r <= VALUE_WIDTH'(in_val);
      bkt_r <= BKT_W'(in_key % BUCKETS);
    end
    head_rd_r <= head_mem[bkt_r];
    hvld_r    <= head_vld_r[bkt_r];
    if (cmd.load_head) begin
      ptr_r   <= head_eff;
      steps_r <= '0;
    end
    if (cmd.rd_node) begin
      nkey_r <= key_mem[ptr_r[IDX_W-1:0]];
      nnxt_r <= nxt_mem[ptr_r[IDX_W-1:0]];
    end
    if (cmd.advance) begin
      ptr_r   <= nnxt_r;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.do_write) begin
      if (hit_sel) begin
        val_mem[wr_idx] <= val_r;
      end else if (count_r < PTR_W'(ENTRIES)) begin
        key_mem[wr_idx]  <= key_r;
        val_mem[wr_idx]  <= val_r;
        nxt_mem[wr_idx]  <= head_eff;
        head_mem[bkt_r]  <= count_r;
      end
    end
    if (cmd.rd_node) hit_r <= ptr_r;
  end

  // Result register; for a get hit the value is read from memory in the cycle after the other result fields.
  logic             res_hit_get_r;
  logic [31:0]      res_value_r;
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_found     <= hit_sel;
      res_inserted  <= !hit_sel && op_r && (count_r < PTR_W'(ENTRIES));
      res_full      <= !hit_sel && op_r && (count_r >= PTR_W'(ENTRIES));
      res_value_r   <= (op_r && (hit_sel || count_r < PTR_W'(ENTRIES)))
                       ? 32'(val_r) : 32'd0;
    end
    if (res_hit_get_r) res_value_r <= 32'(val_mem[hit_r[IDX_W-1:0]]);
    if (cmd.set_res) res_hit_get_r <= hit_sel && !op_r;
    else res_hit_get_r <= 1'b0;
  end
  assign res_value = res_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= '0;
      count_r    <= '0;
    end else if (cmd.do_write && !hit_sel && count_r < PTR_W'(ENTRIES)) begin
      head_vld_r[bkt_r] <= 1'b1;
      count_r           <= count_r + 1'b1;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/chained_hash_map_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// chained_hash_map_store: key-value store with separate chaining
// Each request passes head read, head load, a node read and compare for each
// node walked, then commit and result. One request at a time: the next request
// is taken no earlier than the cycle in which the previous result is accepted.
// Reset empties all buckets at once through per-bucket valid bits.
// ---------------------------------------------------------------------------
module chained_hash_map_store (
  input wire logic clk,
  input wire logic rst_n,
  chms_req_if.sink   in_req,
  chms_rsp_if.source out_rsp
);
  import chms_pkg::*;

  chms_cmd_t cmd;
  chms_sts_t sts;

  chms_ctrl u_ctrl (
    .clk, .rst_n,
    .req_valid(in_req.valid), .req_ready(in_req.ready),
    .rsp_valid(out_rsp.valid), .rsp_ready(out_rsp.ready),
    .sts, .cmd
  );

  chms_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_op(in_req.operation), .in_key(in_req.key), .in_val(in_req.value),
    .res_found(out_rsp.found), .res_value(out_rsp.value_out),
    .res_inserted(out_rsp.inserted), .res_full(out_rsp.full_res)
  );
endmodule
`default_nettype wire
